// ----- hw/rtl/dmwtc_pkg.sv -----
`timescale 1ns / 1ps

package dmwtc_pkg;

   // Cache geometry
   localparam int NUM_LINES   = 16;
   localparam int BLOCK_BYTES = 4;
   localparam int STORE_BYTES = 1024;

   // Field widths
   localparam int DATA_W = 8;
   localparam int ADDR_W = 10;
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int IDX_W  = $clog2(NUM_LINES);
   localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
   localparam int LINE_W = IDX_W + OFF_W;
   localparam int STORE_W = $clog2(STORE_BYTES);
   localparam int FCNT_W = OFF_W + 1;

   // Opcodes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_HITRD,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/dmwtc_req_if.sv -----
`timescale 1ns / 1ps

interface dmwtc_req_if
   import dmwtc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ADDR_W-1:0] byte_address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output opcode, output byte_address, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input byte_address, input write_data,
                   output ready);
endinterface

// ----- hw/rtl/dmwtc_rsp_if.sv -----
`timescale 1ns / 1ps

interface dmwtc_rsp_if
   import dmwtc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              hit;

   modport source (output valid, output read_data, output hit, input ready);
   modport sink   (input valid, input read_data, input hit, output ready);
endinterface

// ----- hw/rtl/direct_mapped_write_through_cache_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Transfer when        Payload
// req_ch    in         valid && ready       opcode, byte_address, write_data
// rsp_ch    out        valid && ready       read_data, hit
//
// One access is worked at a time. A read hit goes through accept, tag lookup, line memory
// read and result; a write hit through accept, tag lookup and result; and a miss through
// accept, tag lookup, the fill and result: the fill streams the block out of the
// backing store read port one byte per cycle. The result register frees the request side,
// so the next access can be taken while a result waits for rsp_ch.ready.
// After reset the backing store is swept to its initial pattern (byte i = i mod 256),
// one entry per cycle; req_ch.ready stays low meanwhile.

module direct_mapped_write_through_cache_top
   import dmwtc_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   dmwtc_req_if.sink   req_ch,
   dmwtc_rsp_if.source rsp_ch
   );

   state_type state_ff, state_in;

   // Captured access
   logic              op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] wdata_ff;

   logic [OFF_W-1:0]  off;
   logic [IDX_W-1:0]  idx;
   logic [TAG_W-1:0]  tag;

   // Tag array in flops, valid bits cleared by reset
   logic [NUM_LINES-1:0] line_valid_ff;
   logic [TAG_W-1:0]     line_tag_ff [NUM_LINES];
   logic                 lookup_hit;

   // Line data memory
   logic [DATA_W-1:0] line_mem [NUM_LINES*BLOCK_BYTES];
   logic [DATA_W-1:0] line_rdata_ff;
   logic              line_we;
   logic [LINE_W-1:0] line_waddr;
   logic [DATA_W-1:0] line_wdata;

   // Backing store memory
   logic [DATA_W-1:0]  bs_mem [STORE_BYTES];
   logic [DATA_W-1:0]  bs_rdata_ff;
   logic               bs_we;
   logic [STORE_W-1:0] bs_waddr;
   logic [DATA_W-1:0]  bs_wdata;
   logic [STORE_W-1:0] bs_raddr;

   // Sequencer counters
   logic [STORE_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [FCNT_W-1:0]  fill_cnt_ff, fill_cnt_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [OFF_W-1:0]   rd_off_ff, rd_off_in;
   logic               fill_done;

   // Result staging and output register
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              req_ready;

   assign off = addr_ff[OFF_W-1:0];
   assign idx = addr_ff[OFF_W +: IDX_W];
   assign tag = addr_ff[ADDR_W-1 -: TAG_W];

   assign lookup_hit = line_valid_ff[idx] && (line_tag_ff[idx] == tag);

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;
   assign rsp_ch.hit       = rsp_hit_ff;

   // Capture the access on transfer
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ready) begin
         op_ff    <= req_ch.opcode;
         addr_ff  <= req_ch.byte_address;
         wdata_ff <= req_ch.write_data;
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      fill_cnt_in  = fill_cnt_ff;
      rd_pend_in   = 1'b0;
      rd_off_in    = fill_cnt_ff[OFF_W-1:0];
      res_data_in  = res_data_ff;
      hit_in       = hit_ff;
      fill_done    = 1'b0;
      req_ready    = 1'b0;
      line_we      = 1'b0;
      line_waddr   = {idx, off};
      line_wdata   = wdata_ff;
      bs_we        = 1'b0;
      bs_waddr     = STORE_W'(addr_ff);
      bs_wdata     = wdata_ff;
      bs_raddr     = STORE_W'({tag, idx, fill_cnt_ff[OFF_W-1:0]});
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;

      // Land a fill byte in the cycle after its backing store read
      if (rd_pend_ff) begin
         line_we    = 1'b1;
         line_waddr = {idx, rd_off_ff};
         line_wdata = bs_rdata_ff;
         if (rd_off_ff == off) begin
            res_data_in = bs_rdata_ff;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            bs_we      = 1'b1;
            bs_waddr   = clr_cnt_ff;
            bs_wdata   = DATA_W'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == STORE_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            hit_in      = lookup_hit;
            fill_cnt_in = '0;
            // Write through now; a following fill then reads the new byte
            if (op_ff == OP_WRITE) begin
               bs_we = 1'b1;
            end
            if (lookup_hit) begin
               if (op_ff == OP_WRITE) begin
                  line_we     = 1'b1;
                  res_data_in = wdata_ff;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_HITRD;
               end
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_HITRD: begin
            res_data_in = line_rdata_ff;
            state_in    = ST_DONE;
         end
         ST_FILL: begin
            if (fill_cnt_ff == FCNT_W'(BLOCK_BYTES)) begin
               fill_done = 1'b1;
               state_in  = ST_DONE;
            end else begin
               rd_pend_in  = 1'b1;
               fill_cnt_in = fill_cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fill_done) begin
            line_valid_ff[idx] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fill_cnt_ff <= fill_cnt_in;
      rd_off_ff   <= rd_off_in;
      res_data_ff <= res_data_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
      if (fill_done) begin
         line_tag_ff[idx] <= tag;
      end
   end

   // Line data memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= line_wdata;
      end
      line_rdata_ff <= line_mem[{idx, off}];
   end

   // Backing store memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (bs_we) begin
         bs_mem[bs_waddr] <= bs_wdata;
      end
      bs_rdata_ff <= bs_mem[bs_raddr];
   end

   // A new result only ever comes from the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the result state");

   // A completed fill leaves the line valid under the access tag
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_FILL) && state_ff == ST_DONE) |->
         (line_valid_ff[idx] && line_tag_ff[idx] == tag))
      else $error("line not valid with its tag after fill");

   // Fill bytes land only during a fill
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == ST_FILL)
      else $error("fill byte pending outside a fill");

   // No transfer is taken while the backing store is being swept
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during store sweep");

endmodule
